/* rtl/core/tgni_pkg.sv */
// Shared constants and register codes for the toroidal grid neighbour index block.
package tgni_pkg;

    // Fixed field widths
    localparam int IDX_W     = 20;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int SLOT_W    = 3;

    // Default grid side limit
    localparam int MAX_SIDE_DEF = 1024;

    // Divider: bits retired per pipeline stage
    localparam int DIV_STEPS = 2;

    // Result queue between the divider pipeline and the emitter
    localparam int QUEUE_D = 16;

    // Register reset values
    localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = 11'd1024;

    // Neighbourhood modes
    localparam logic MODE_MOORE = 1'b0;
    localparam logic MODE_VN    = 1'b1;

    // Final slot of each neighbourhood
    localparam logic [SLOT_W-1:0] SLOT_LAST_MOORE = 3'd7;
    localparam logic [SLOT_W-1:0] SLOT_LAST_VN    = 3'd3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 2'd0,
        REG_GRID_HEIGHT = 2'd1,
        REG_NBHD_MODE   = 2'd2
    } t_reg_idx;

endpackage

/* rtl/core/toroidal_grid_neighbour_index.sv */
// Each accepted item passes the divider stages, stages C and D, the queue, the emitter and
// the output register and leaves as 8 results in Moore mode or 4 in von Neumann mode, one
// per cycle, which sets the item rate. The divider pipeline takes an item every cycle while
// busy is low; a 16-entry queue decouples it from the emitter, busy rising at 16 in flight.
// Reset (synchronous, active low) empties the pipeline and queue and restores the registers.
// The receiver cannot stall: each result is shown for exactly one cycle on o_valid.
module toroidal_grid_neighbour_index #(
    parameter int MAX_SIDE = tgni_pkg::MAX_SIDE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            start,
    output logic                            busy,
    input  logic [tgni_pkg::IDX_W-1:0]      i_cell_index,
    // configuration port
    input  logic                            i_cfg_we,
    input  logic [tgni_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tgni_pkg::CFG_W-1:0]      i_cfg_data,
    // results
    output logic                            o_valid,
    output logic [tgni_pkg::IDX_W-1:0]      o_neighbour_index,
    output logic [tgni_pkg::SLOT_W-1:0]     o_neighbour_slot,
    output logic                            o_last_neighbour
);

    localparam int IDX_W   = tgni_pkg::IDX_W;
    localparam int CFG_W   = tgni_pkg::CFG_W;
    localparam int SLOT_W  = tgni_pkg::SLOT_W;
    localparam int SIDE_NB = $clog2(MAX_SIDE + 1);
    localparam int SIDE_W  = (SIDE_NB < CFG_W) ? SIDE_NB : CFG_W;
    localparam int NSTG    = IDX_W / tgni_pkg::DIV_STEPS;
    localparam int QPTR_W  = $clog2(tgni_pkg::QUEUE_D);
    localparam int CRED_W  = QPTR_W + 1;

    typedef struct packed {
        logic [SIDE_W-1:0] rem;
        logic [IDX_W-1:0]  num;
    } t_div;

    typedef struct packed {
        logic [SIDE_W-1:0] x;
        logic [SIDE_W-1:0] xm;
        logic [SIDE_W-1:0] xp;
        logic [IDX_W-1:0]  bm;
        logic [IDX_W-1:0]  b0;
        logic [IDX_W-1:0]  bp;
    } t_qent;

    // Side clamp: zero reads as one, oversized reads as MAX_SIDE
    function automatic logic [SIDE_W-1:0] side_clamp(input logic [CFG_W-1:0] s);
        logic [SIDE_W-1:0] r;
        if (s == '0) begin
            r = SIDE_W'(1);
        end else if (32'(s) > MAX_SIDE) begin
            r = SIDE_W'(MAX_SIDE);
        end else begin
            r = SIDE_W'(s);
        end
        return r;
    endfunction

    // Restoring division steps: shift a dividend bit into the remainder, quotient bit in
    function automatic t_div div_steps(input t_div a, input logic [SIDE_W-1:0] d);
        t_div             v;
        logic [SIDE_W:0]  t;
        logic             qb;
        v = a;
        for (int k = 0; k < tgni_pkg::DIV_STEPS; k++) begin
            t  = {v.rem, v.num[IDX_W-1]};
            qb = (t >= {1'b0, d});
            if (qb) begin
                t = t - {1'b0, d};
            end
            v.rem = t[SIDE_W-1:0];
            v.num = {v.num[IDX_W-2:0], qb};
        end
        return v;
    endfunction

    // Configuration registers
    logic [CFG_W-1:0] r_grid_width;
    logic [CFG_W-1:0] r_grid_height;
    logic             r_nbhd_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= tgni_pkg::GRID_WIDTH_RST;
            r_grid_height <= tgni_pkg::GRID_HEIGHT_RST;
            r_nbhd_mode   <= tgni_pkg::MODE_MOORE;
        end else if (i_cfg_we) begin
            unique case (tgni_pkg::t_reg_idx'(i_cfg_idx))
                tgni_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                tgni_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                tgni_pkg::REG_NBHD_MODE:   r_nbhd_mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [SIDE_W-1:0] side_w;
    logic [SIDE_W-1:0] side_h;
    assign side_w = side_clamp(r_grid_width);
    assign side_h = side_clamp(r_grid_height);

    // Credit count: items accepted and not yet taken from the queue
    logic              accept;
    logic              q_pop;
    logic [CRED_W-1:0] r_credit;

    assign accept = start && !busy;
    assign busy   = (r_credit == CRED_W'(tgni_pkg::QUEUE_D));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CRED_W'(accept) - CRED_W'(q_pop);
        end
    end

    // Phase A: index / width, remainder is the column
    logic [NSTG:0]     r_a_vld;
    logic [SIDE_W-1:0] r_a_rem [0:NSTG];
    logic [IDX_W-1:0]  r_a_num [0:NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld[0] <= 1'b0;
        end else begin
            r_a_vld[0] <= accept;
        end
        r_a_rem[0] <= '0;
        r_a_num[0] <= i_cell_index;
    end

    for (genvar s = 1; s <= NSTG; s++) begin : g_a
        t_div n_a;
        always_comb begin
            n_a = div_steps('{rem: r_a_rem[s-1], num: r_a_num[s-1]}, side_w);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld[s] <= 1'b0;
            end else begin
                r_a_vld[s] <= r_a_vld[s-1];
            end
            r_a_rem[s] <= n_a.rem;
            r_a_num[s] <= n_a.num;
        end
    end

    // Phase B: quotient mod height gives the row, column rides along
    logic [NSTG:1]     r_b_vld;
    logic [SIDE_W-1:0] r_b_rem [1:NSTG];
    logic [IDX_W-1:0]  r_b_num [1:NSTG];
    logic [SIDE_W-1:0] r_b_x   [1:NSTG];

    for (genvar s = 1; s <= NSTG; s++) begin : g_b
        t_div              src;
        logic              src_vld;
        logic [SIDE_W-1:0] src_x;
        t_div              n_b;
        if (s == 1) begin : g_first
            always_comb begin
                src     = '{rem: '0, num: r_a_num[NSTG]};
                src_vld = r_a_vld[NSTG];
                src_x   = r_a_rem[NSTG];
            end
        end else begin : g_next
            always_comb begin
                src     = '{rem: r_b_rem[s-1], num: r_b_num[s-1]};
                src_vld = r_b_vld[s-1];
                src_x   = r_b_x[s-1];
            end
        end
        always_comb begin
            n_b = div_steps(src, side_h);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_b_vld[s] <= 1'b0;
            end else begin
                r_b_vld[s] <= src_vld;
            end
            r_b_rem[s] <= n_b.rem;
            r_b_num[s] <= n_b.num;
            r_b_x[s]   <= src_x;
        end
    end

    // Stage C: wrapped steps of column and row
    logic              r_c_vld;
    logic [SIDE_W-1:0] r_c_x, r_c_xm, r_c_xp;
    logic [SIDE_W-1:0] r_c_y, r_c_ym, r_c_yp;
    logic [SIDE_W-1:0] c_x, c_y;
    logic [SIDE_W:0]   c_x_inc, c_y_inc;

    assign c_x     = r_b_x[NSTG];
    assign c_y     = r_b_rem[NSTG];
    assign c_x_inc = {1'b0, c_x} + (SIDE_W+1)'(1);
    assign c_y_inc = {1'b0, c_y} + (SIDE_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld[NSTG];
        end
        r_c_x  <= c_x;
        r_c_y  <= c_y;
        r_c_xm <= (c_x == '0) ? side_w - SIDE_W'(1) : c_x - SIDE_W'(1);
        r_c_ym <= (c_y == '0) ? side_h - SIDE_W'(1) : c_y - SIDE_W'(1);
        r_c_xp <= (c_x_inc >= {1'b0, side_w}) ? '0 : c_x_inc[SIDE_W-1:0];
        r_c_yp <= (c_y_inc >= {1'b0, side_h}) ? '0 : c_y_inc[SIDE_W-1:0];
    end

    // Stage D: row bases, one multiply per row
    logic  r_d_vld;
    t_qent r_d_ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else begin
            r_d_vld <= r_c_vld;
        end
        r_d_ent.x  <= r_c_x;
        r_d_ent.xm <= r_c_xm;
        r_d_ent.xp <= r_c_xp;
        r_d_ent.bm <= IDX_W'(r_c_ym) * IDX_W'(side_w);
        r_d_ent.b0 <= IDX_W'(r_c_y) * IDX_W'(side_w);
        r_d_ent.bp <= IDX_W'(r_c_yp) * IDX_W'(side_w);
    end

    // Result queue; never overflows since credits bound the items in flight
    t_qent             r_q_mem [tgni_pkg::QUEUE_D];
    logic [QPTR_W-1:0] r_q_wptr, r_q_rptr;
    logic [CRED_W-1:0] r_q_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wptr <= '0;
            r_q_rptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (r_d_vld) begin
                r_q_wptr <= r_q_wptr + QPTR_W'(1);
            end
            if (q_pop) begin
                r_q_rptr <= r_q_rptr + QPTR_W'(1);
            end
            r_q_cnt <= r_q_cnt + CRED_W'(r_d_vld) - CRED_W'(q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_d_vld) begin
            r_q_mem[r_q_wptr] <= r_d_ent;
        end
    end

    // Emitter: walks the slots of the current item
    logic              r_e_vld;
    logic [SLOT_W-1:0] r_e_slot;
    t_qent             r_e_ent;
    logic [SLOT_W-1:0] e_last_slot;
    logic              e_last;

    assign e_last_slot = (r_nbhd_mode == tgni_pkg::MODE_VN) ?
                         tgni_pkg::SLOT_LAST_VN : tgni_pkg::SLOT_LAST_MOORE;
    assign e_last      = (r_e_slot == e_last_slot);
    assign q_pop       = (r_q_cnt != '0) && (!r_e_vld || e_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld  <= 1'b0;
            r_e_slot <= '0;
        end else if (q_pop) begin
            r_e_vld  <= 1'b1;
            r_e_slot <= '0;
        end else if (r_e_vld) begin
            r_e_vld  <= !e_last;
            r_e_slot <= r_e_slot + SLOT_W'(1);
        end
        if (q_pop) begin
            r_e_ent <= r_q_mem[r_q_rptr];
        end
    end

    // Column and row base for the current slot
    logic [SIDE_W-1:0] e_col;
    logic [IDX_W-1:0]  e_base;

    always_comb begin
        e_col  = r_e_ent.x;
        e_base = r_e_ent.b0;
        if (r_nbhd_mode == tgni_pkg::MODE_VN) begin
            // +x, -x, +y, -y
            unique case (r_e_slot)
                3'd0:    begin e_col = r_e_ent.xp; e_base = r_e_ent.b0; end
                3'd1:    begin e_col = r_e_ent.xm; e_base = r_e_ent.b0; end
                3'd2:    begin e_col = r_e_ent.x;  e_base = r_e_ent.bp; end
                3'd3:    begin e_col = r_e_ent.x;  e_base = r_e_ent.bm; end
                default: begin e_col = r_e_ent.x;  e_base = r_e_ent.b0; end
            endcase
        end else begin
            // rows above, centre, below; columns left to right, centre skipped
            unique case (r_e_slot)
                3'd0:    begin e_col = r_e_ent.xm; e_base = r_e_ent.bm; end
                3'd1:    begin e_col = r_e_ent.x;  e_base = r_e_ent.bm; end
                3'd2:    begin e_col = r_e_ent.xp; e_base = r_e_ent.bm; end
                3'd3:    begin e_col = r_e_ent.xm; e_base = r_e_ent.b0; end
                3'd4:    begin e_col = r_e_ent.xp; e_base = r_e_ent.b0; end
                3'd5:    begin e_col = r_e_ent.xm; e_base = r_e_ent.bp; end
                3'd6:    begin e_col = r_e_ent.x;  e_base = r_e_ent.bp; end
                default: begin e_col = r_e_ent.xp; e_base = r_e_ent.bp; end
            endcase
        end
    end

    // Output register
    logic              r_out_vld;
    logic [IDX_W-1:0]  r_out_idx;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_e_vld;
        end
        r_out_idx  <= IDX_W'(e_col) + e_base;
        r_out_slot <= r_e_slot;
        r_out_last <= e_last;
    end

    assign o_valid           = r_out_vld;
    assign o_neighbour_index = r_out_idx;
    assign o_neighbour_slot  = r_out_slot;
    assign o_last_neighbour  = r_out_last;

endmodule

/* rtl/core/tgni_chk.sv */
// Port-level checker for the toroidal grid neighbour index block, bound to the top level.
module tgni_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            busy,
    input logic                            o_valid,
    input logic [tgni_pkg::SLOT_W-1:0]     o_neighbour_slot,
    input logic                            o_last_neighbour
);

    // Results of one item leave in consecutive cycles with rising slots
    a_slot_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_neighbour |=>
            o_valid && (o_neighbour_slot == $past(o_neighbour_slot) + 3'd1))
        else $error("slot run broken");

    // The last flag only on a final slot of either neighbourhood
    a_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_neighbour |->
            (o_neighbour_slot == tgni_pkg::SLOT_LAST_MOORE) ||
            (o_neighbour_slot == tgni_pkg::SLOT_LAST_VN))
        else $error("last flag on wrong slot");

    // A nonzero slot always continues an unfinished item
    a_slot_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_neighbour_slot != 3'd0) |-> $past(o_valid && !o_last_neighbour))
        else $error("result without its predecessor");

    // Reset leaves no result pending and the block ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !busy)
        else $error("outputs active after reset");

endmodule

bind toroidal_grid_neighbour_index tgni_chk u_tgni_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_neighbour_slot (o_neighbour_slot),
    .o_last_neighbour (o_last_neighbour)
);

/* verif/toroidal_grid_neighbour_index_tb.sv */
// Self-checking testbench for the toroidal grid neighbour index block.
module toroidal_grid_neighbour_index_tb;

    localparam int CLK_PERIOD = 12;
    localparam int IDX_W      = tgni_pkg::IDX_W;
    localparam int CFG_W      = tgni_pkg::CFG_W;
    localparam int CFG_IDX_W  = tgni_pkg::CFG_IDX_W;
    localparam int SLOT_W     = tgni_pkg::SLOT_W;
    localparam int MAX_SIDE   = tgni_pkg::MAX_SIDE_DEF;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 40;
    localparam int TAIL_WAIT  = 40;

    localparam logic MODE_MOORE = tgni_pkg::MODE_MOORE;
    localparam logic MODE_VN    = tgni_pkg::MODE_VN;
    localparam logic [SLOT_W-1:0] SLOT_LAST_MOORE = tgni_pkg::SLOT_LAST_MOORE;
    localparam logic [SLOT_W-1:0] SLOT_LAST_VN    = tgni_pkg::SLOT_LAST_VN;

    // One neighbour result as it leaves the block
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_nbr_result;

    // Directed row: grid setting, centre cell, optional hand-computed neighbours
    typedef struct packed {
        logic [CFG_W-1:0]           w;
        logic [CFG_W-1:0]           h;
        logic                       mode;
        logic [IDX_W-1:0]           ctr;
        logic                       typed;
        logic [0:7][IDX_W-1:0]      nbr;
    } t_dir_row;

    localparam int N_DIR = 18;
    localparam logic [0:7][IDX_W-1:0] NO_NBR = '0;

    localparam t_dir_row DIR_TABLE [N_DIR] = '{
        // reset grid, corner cells and an interior cell on a full 1024 x 1024 torus
        '{11'd1024, 11'd1024, MODE_MOORE, 20'd0, 1'b1,
          '{20'd1048575, 20'd1047552, 20'd1047553, 20'd1023,
            20'd1, 20'd2047, 20'd1024, 20'd1025}},
        '{11'd1024, 11'd1024, MODE_MOORE, 20'hFFFFF, 1'b1,
          '{20'd1047550, 20'd1047551, 20'd1046528, 20'd1048574,
            20'd1047552, 20'd1022, 20'd1023, 20'd0}},
        '{11'd1024, 11'd1024, MODE_MOORE, 20'd5000, 1'b0, NO_NBR},
        // single-cell torus: every step lands back on cell 0
        '{11'd1, 11'd1, MODE_MOORE, 20'd0, 1'b1, '{default: 20'd0}},
        '{11'd1, 11'd1, MODE_MOORE, 20'hFFFFF, 1'b1, '{default: 20'd0}},
        // zero sides behave as one
        '{11'd0, 11'd0, MODE_VN, 20'hFFFFF, 1'b1, '{default: 20'd0}},
        '{11'd0, 11'd7, MODE_MOORE, 20'd12, 1'b0, NO_NBR},
        // oversized sides clamp to the limit
        '{11'd2047, 11'd2047, MODE_VN, 20'd0, 1'b1,
          '{20'd1, 20'd1023, 20'd1024, 20'd1047552, 20'd0, 20'd0, 20'd0, 20'd0}},
        '{11'd1025, 11'd3, MODE_VN, 20'hABCDE, 1'b0, NO_NBR},
        // side of one along a single axis
        '{11'd1, 11'd5, MODE_MOORE, 20'd4, 1'b0, NO_NBR},
        '{11'd6, 11'd1, MODE_VN, 20'd5, 1'b0, NO_NBR},
        // small grid, two corners and the interior
        '{11'd7, 11'd3, MODE_VN, 20'd0, 1'b0, NO_NBR},
        '{11'd7, 11'd3, MODE_VN, 20'd20, 1'b0, NO_NBR},
        '{11'd7, 11'd3, MODE_VN, 20'd8, 1'b0, NO_NBR},
        // index beyond the grid folds onto the torus, then cells inside the grid
        '{11'd3, 11'd2, MODE_MOORE, 20'd1000, 1'b0, NO_NBR},
        '{11'd1024, 11'd1, MODE_MOORE, 20'hFFFFF, 1'b0, NO_NBR},
        '{11'd2, 11'd2, MODE_MOORE, 20'd3, 1'b0, NO_NBR},
        '{11'd1023, 11'd1024, MODE_VN, 20'h80000, 1'b0, NO_NBR}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [IDX_W-1:0]     i_cell_index;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 o_valid;
    logic [IDX_W-1:0]     o_neighbour_index;
    logic [SLOT_W-1:0]    o_neighbour_slot;
    logic                 o_last_neighbour;

    // Local copy of the grid registers
    logic [CFG_W-1:0] grid_w_reg;
    logic [CFG_W-1:0] grid_h_reg;
    logic             nbhd_mode_reg;

    t_nbr_result nbr_expected[$];
    int          err_count;
    int          idle_pct;

    toroidal_grid_neighbour_index i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cell_index      (i_cell_index),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_neighbour_index (o_neighbour_index),
        .o_neighbour_slot  (o_neighbour_slot),
        .o_last_neighbour  (o_last_neighbour)
    );

    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Side actually used: zero acts as one, oversize clamps
    function automatic int unsigned side_in_use(input logic [CFG_W-1:0] s);
        if (s == '0) begin
            return 1;
        end
        if (s > MAX_SIDE) begin
            return MAX_SIDE;
        end
        return s;
    endfunction

    // One wrapped step along an axis of length n
    function automatic int unsigned torus_step(input int unsigned v, input int d,
                                               input int unsigned n);
        if (d < 0) begin
            return (v == 0) ? n - 1 : v - 1;
        end
        if (d > 0) begin
            return (v + 1 >= n) ? 0 : v + 1;
        end
        return v;
    endfunction

    function automatic void push_neighbour(input int unsigned idx, input int slot,
                                           input logic last);
        t_nbr_result r;
        r.idx  = idx[IDX_W-1:0];
        r.slot = slot[SLOT_W-1:0];
        r.last = last;
        nbr_expected = {nbr_expected, r};
    endfunction

    // Neighbours of one centre cell under the current grid setting
    function automatic void predict_neighbours(input logic [IDX_W-1:0] ctr_idx);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int          k;
        int          dx;
        int          dy;
        w = side_in_use(grid_w_reg);
        h = side_in_use(grid_h_reg);
        x = ctr_idx % w;
        y = (ctr_idx / w) % h;
        k = 0;
        if (nbhd_mode_reg == MODE_MOORE) begin
            for (dy = -1; dy <= 1; dy++) begin
                for (dx = -1; dx <= 1; dx++) begin
                    if (dx != 0 || dy != 0) begin
                        push_neighbour(torus_step(x, dx, w) + torus_step(y, dy, h) * w,
                                       k, k == SLOT_LAST_MOORE);
                        k++;
                    end
                end
            end
        end else begin
            // +x, -x, +y, -y
            for (k = 0; k < 4; k++) begin
                dx = (k == 0) ? 1 : (k == 1) ? -1 : 0;
                dy = (k == 2) ? 1 : (k == 3) ? -1 : 0;
                push_neighbour(torus_step(x, dx, w) + torus_step(y, dy, h) * w,
                               k, k == SLOT_LAST_VN);
            end
        end
    endfunction

    // Offer one cell, with random idle cycles first; returns after an edge at which busy reads low
    task automatic send_cell(input logic [IDX_W-1:0] ctr_idx);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start        <= 1'b1;
        i_cell_index <= ctr_idx;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Stop offering items and wait until every expected neighbour has come out
    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (nbr_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write all three registers on consecutive cycles
    task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic mode);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= tgni_pkg::REG_GRID_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= tgni_pkg::REG_GRID_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_idx  <= tgni_pkg::REG_NBHD_MODE;
        i_cfg_data <= {{(CFG_W-1){1'b0}}, mode};
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        grid_w_reg    = w;
        grid_h_reg    = h;
        nbhd_mode_reg = mode;
    endtask

    // Random side register value, biased toward the corners
    function automatic logic [CFG_W-1:0] pick_side();
        case ($urandom_range(9))
            0: return '0;
            1: return 11'd1;
            2: return 11'd2;
            3: return 11'd1024;
            4: return 11'd1023;
            5: return 11'(1025 + $urandom_range(1021));
            6: return 11'd2047;
            default: return 11'($urandom_range(1, 40));
        endcase
    endfunction

    // Random centre cell: full range, grid edges, or inside the grid
    function automatic logic [IDX_W-1:0] pick_cell();
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        w = side_in_use(grid_w_reg);
        h = side_in_use(grid_h_reg);
        case ($urandom_range(3))
            1: begin
                x = $urandom_range(1) ? w - 1 : 0;
                y = $urandom_range(1) ? h - 1 : 0;
                return IDX_W'(x + y * w);
            end
            2: return IDX_W'($urandom_range(w * h - 1));
            default: return IDX_W'($urandom);
        endcase
    endfunction

    // Result checker: the receiver cannot stall, so every strobe is a result
    always @(posedge i_clk) begin
        t_nbr_result exp_r;
        if (i_rst_n && o_valid) begin
            if (nbr_expected.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected result: idx %0d slot %0d last %0b",
                             o_neighbour_index, o_neighbour_slot, o_last_neighbour);
                end
            end else begin
                exp_r = nbr_expected.pop_front();
                if (o_neighbour_index !== exp_r.idx || o_neighbour_slot !== exp_r.slot ||
                    o_last_neighbour !== exp_r.last) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: expected idx %0d slot %0d last %0b,",
                                 exp_r.idx, exp_r.slot, exp_r.last,
                                 " got idx %0d slot %0d last %0b", o_neighbour_index,
                                 o_neighbour_slot, o_last_neighbour);
                    end
                end
            end
        end
    end

    // Main sequence
    initial begin
        int idle_modes[3];
        int r;
        int p;
        int n;
        int k;
        idle_modes    = '{0, 67, 7};
        err_count     = 0;
        idle_pct      = 0;
        grid_w_reg    = tgni_pkg::GRID_WIDTH_RST;
        grid_h_reg    = tgni_pkg::GRID_HEIGHT_RST;
        nbhd_mode_reg = MODE_MOORE;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_cell_index <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= tgni_pkg::REG_GRID_WIDTH;
        i_cfg_data   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; the first ones run on the reset grid setting
        for (r = 0; r < N_DIR; r++) begin
            if (DIR_TABLE[r].w != grid_w_reg || DIR_TABLE[r].h != grid_h_reg ||
                DIR_TABLE[r].mode != nbhd_mode_reg) begin
                drain();
                set_grid(DIR_TABLE[r].w, DIR_TABLE[r].h, DIR_TABLE[r].mode);
            end
            send_cell(DIR_TABLE[r].ctr);
            if (DIR_TABLE[r].typed) begin
                n = (DIR_TABLE[r].mode == MODE_MOORE) ? 8 : 4;
                for (k = 0; k < n; k++) begin
                    push_neighbour(DIR_TABLE[r].nbr[k], k, k == n - 1);
                end
            end else begin
                predict_neighbours(DIR_TABLE[r].ctr);
            end
        end

        // Random phases, each with its own grid setting and idle rate
        for (p = 0; p < N_PHASES; p++) begin
            drain();
            set_grid(pick_side(), pick_side(), 1'($urandom_range(1)));
            idle_pct = idle_modes[p % 3];
            for (n = 0; n < PHASE_LEN; n++) begin
                logic [IDX_W-1:0] ctr_idx;
                ctr_idx = pick_cell();
                send_cell(ctr_idx);
                predict_neighbours(ctr_idx);
            end
        end

        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        err_count += nbr_expected.size();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(CLK_PERIOD * 300000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
